### rtl/core/lacc_pkg.sv
// ============================================================================
// lacc_pkg
// Shared types, constants and control bundles of the crossing counter.
// ============================================================================
`default_nettype none

package lacc_pkg;

    localparam int NODE_W        = 6;
    localparam int CMD_W         = 2;
    localparam int COUNT_W       = 7;
    localparam int CROSS_W       = 20;
    localparam int MAX_NODES_DEF = 64;
    localparam int MIN_NODES     = 4;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

    // register select bit of paddr (byte address 4*i)
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_SET_POS  = 2'd2,
        CMD_COMPUTE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_B,
        ST_RB_RD,
        ST_RB_WR,
        ST_U_RD,
        ST_U_LD,
        ST_V_CHK,
        ST_V_LD,
        ST_W_CHK,
        ST_W_HOLD,
        ST_W_LD,
        ST_Z_CHK,
        ST_Z_LD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [NODE_W-1:0] position;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_a;
        cmd_t              cmd;
    } item_t;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [NODE_W-1:0] wbit;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } adj_ctrl_t;

    typedef struct packed {
        logic              npos_we;
        logic [NODE_W-1:0] npos_waddr;
        logic [NODE_W-1:0] npos_wdata;
        logic              npos_re;
        logic [NODE_W-1:0] npos_raddr;
        logic              held_clr;
        logic              hold_we;
        logic [NODE_W-1:0] hold_waddr;
        logic              hold_wvalid;
        logic [NODE_W-1:0] hold_wnode;
        logic              hold_re;
        logic [NODE_W-1:0] hold_raddr;
    } pos_ctrl_t;

    typedef struct packed {
        logic [NODE_W-1:0] npos_q;
        logic              held_at;
        logic [NODE_W-1:0] hold_q;
    } pos_stat_t;

endpackage

`default_nettype wire

### rtl/core/lacc_adj_store.sv
// ============================================================================
// lacc_adj_store
// Adjacency bit matrix, one row per node, with per-row valid bits so a
// clear resets every row at once. Invalid rows read as zero.
// ============================================================================
`default_nettype none

module lacc_adj_store #(
    parameter int SLOTS = lacc_pkg::MAX_NODES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lacc_pkg::adj_ctrl_t ctrl,
    output logic [SLOTS-1:0]         row_q
);

    localparam int AW = $clog2(SLOTS);

    logic [SLOTS-1:0] adj_mem [SLOTS];
    logic [SLOTS-1:0] row_valid_reg;
    logic [SLOTS-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    wa;
    logic [AW-1:0]    wb;
    logic [AW-1:0]    ra;
    logic [SLOTS-1:0] onehot;

    assign wa     = ctrl.waddr[AW-1:0];
    assign wb     = ctrl.wbit[AW-1:0];
    assign ra     = ctrl.raddr[AW-1:0];
    assign onehot = SLOTS'(1) << wb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ctrl.clr) begin
            row_valid_reg <= '0;
        end else if (ctrl.we) begin
            row_valid_reg[wa] <= 1'b1;
        end
    end

    // first write to a stale row replaces it whole
    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            if (row_valid_reg[wa]) begin
                adj_mem[wa][wb] <= 1'b1;
            end else begin
                adj_mem[wa] <= onehot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.re) begin
            rd_data_reg  <= adj_mem[ra];
            rd_valid_reg <= row_valid_reg[ra];
        end
    end

    assign row_q = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### rtl/core/lacc_pos_store.sv
// ============================================================================
// lacc_pos_store
// Node positions (identity until written) and the position holder table
// rebuilt at the start of every count.
// ============================================================================
`default_nettype none

module lacc_pos_store #(
    parameter int SLOTS = lacc_pkg::MAX_NODES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lacc_pkg::pos_ctrl_t ctrl,
    output lacc_pkg::pos_stat_t      stat
);

    localparam int AW = $clog2(SLOTS);

    logic [lacc_pkg::NODE_W-1:0] npos_mem [SLOTS];
    logic [SLOTS-1:0]            npos_valid_reg;
    logic [lacc_pkg::NODE_W-1:0] npos_q_reg;
    logic [lacc_pkg::NODE_W-1:0] holder_mem [SLOTS];
    logic [SLOTS-1:0]            held_reg;
    logic [lacc_pkg::NODE_W-1:0] hold_q_reg;
    logic [AW-1:0]               npos_wa;
    logic [AW-1:0]               npos_ra;
    logic [AW-1:0]               hold_wa;
    logic [AW-1:0]               hold_ra;

    assign npos_wa = ctrl.npos_waddr[AW-1:0];
    assign npos_ra = ctrl.npos_raddr[AW-1:0];
    assign hold_wa = ctrl.hold_waddr[AW-1:0];
    assign hold_ra = ctrl.hold_raddr[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            npos_valid_reg <= '0;
            held_reg       <= '0;
        end else begin
            if (ctrl.npos_we) begin
                npos_valid_reg[npos_wa] <= 1'b1;
            end
            if (ctrl.held_clr) begin
                held_reg <= '0;
            end else if (ctrl.hold_we) begin
                held_reg[hold_wa] <= ctrl.hold_wvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.npos_we) begin
            npos_mem[npos_wa] <= ctrl.npos_wdata;
        end
        if (ctrl.npos_re) begin
            npos_q_reg <= npos_valid_reg[npos_ra] ? npos_mem[npos_ra]
                                                  : lacc_pkg::NODE_W'(npos_ra);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.hold_we) begin
            holder_mem[hold_wa] <= ctrl.hold_wnode;
        end
        if (ctrl.hold_re) begin
            hold_q_reg <= holder_mem[hold_ra];
        end
    end

    assign stat.npos_q  = npos_q_reg;
    assign stat.held_at = held_reg[hold_ra];
    assign stat.hold_q  = hold_q_reg;

endmodule

`default_nettype wire

### rtl/core/lacc_seq.sv
// ============================================================================
// lacc_seq
// Command decode and counting sequencer: rebuilds the holder table, then
// walks edges (u,v), inner positions and neighbors z with position compares and
// one saturating counter.
// ============================================================================
`default_nettype none

module lacc_seq #(
    parameter int MAX_NODES = lacc_pkg::MAX_NODES_DEF,
    parameter int SLOTS     = lacc_pkg::MAX_NODES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lacc_pkg::item_t               item,
    input  wire logic [lacc_pkg::COUNT_W-1:0]  node_count,
    input  wire logic                          out_free,
    output logic                               res_valid,
    output logic [lacc_pkg::CROSS_W-1:0]       res_cross,
    output lacc_pkg::adj_ctrl_t                adj_ctrl,
    input  wire logic [SLOTS-1:0]              row_q,
    output lacc_pkg::pos_ctrl_t                pos_ctrl,
    input  wire lacc_pkg::pos_stat_t           pos_stat
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = lacc_pkg::NODE_W;
    localparam int KW = lacc_pkg::COUNT_W;

    lacc_pkg::state_t state_reg, state_next;

    logic [KW-1:0]               n_reg, n_next;
    logic [CW-1:0]               m_reg, m_next;
    logic [KW-1:0]               i_reg, i_next;
    logic [CW-1:0]               u_reg, u_next;
    logic [CW-1:0]               v_reg, v_next;
    logic [CW-1:0]               z_reg, z_next;
    logic [NW-1:0]               pu_reg, pu_next;
    logic [NW-1:0]               pv_reg, pv_next;
    logic [NW-1:0]               pw_reg, pw_next;
    logic [NW-1:0]               a_reg, a_next;
    logic [NW-1:0]               b_reg, b_next;
    logic [SLOTS-1:0]            row_u_reg, row_u_next;
    logic [SLOTS-1:0]            row_w_reg, row_w_next;
    logic [lacc_pkg::CROSS_W-1:0] cnt_reg, cnt_next;

    logic          edge_ok;
    logic [KW-1:0] n_clamp;
    logic [CW-1:0] m_clamp;
    logic          i_in_store;
    logic          pw_held;
    logic          u_bit;
    logic          w_bit;

    assign edge_ok = (item.node_a != item.node_b) && (int'(item.node_a) < SLOTS)
                     && (int'(item.node_b) < SLOTS);
    assign n_clamp = (int'(node_count) > MAX_NODES) ? KW'(MAX_NODES) : node_count;
    assign m_clamp = (int'(n_clamp) > SLOTS) ? CW'(SLOTS) : CW'(n_clamp);
    assign i_in_store = int'(i_reg) < SLOTS;
    assign pw_held = (int'(pw_reg) < SLOTS) && pos_stat.held_at;
    assign u_bit   = row_u_reg[v_reg[AW-1:0]];
    assign w_bit   = row_w_reg[z_reg[AW-1:0]];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lacc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    case (item.cmd)
                        lacc_pkg::CMD_ADD_EDGE: begin
                            if (edge_ok) begin
                                state_next = lacc_pkg::ST_EDGE_B;
                            end
                        end
                        lacc_pkg::CMD_COMPUTE: begin
                            state_next = (int'(n_clamp) < lacc_pkg::MIN_NODES)
                                         ? lacc_pkg::ST_DONE : lacc_pkg::ST_RB_RD;
                        end
                        default: state_next = lacc_pkg::ST_IDLE;
                    endcase
                end
            end
            lacc_pkg::ST_EDGE_B: state_next = lacc_pkg::ST_IDLE;
            lacc_pkg::ST_RB_RD: begin
                if (i_reg == n_reg) begin
                    state_next = lacc_pkg::ST_U_RD;
                end else if (i_in_store) begin
                    state_next = lacc_pkg::ST_RB_WR;
                end
            end
            lacc_pkg::ST_RB_WR: state_next = lacc_pkg::ST_RB_RD;
            lacc_pkg::ST_U_RD: begin
                state_next = (u_reg == m_reg) ? lacc_pkg::ST_DONE : lacc_pkg::ST_U_LD;
            end
            lacc_pkg::ST_U_LD: state_next = lacc_pkg::ST_V_CHK;
            lacc_pkg::ST_V_CHK: begin
                if (v_reg == m_reg) begin
                    state_next = lacc_pkg::ST_U_RD;
                end else if (u_bit) begin
                    state_next = lacc_pkg::ST_V_LD;
                end
            end
            lacc_pkg::ST_V_LD: begin
                state_next = (pu_reg < pos_stat.npos_q) ? lacc_pkg::ST_W_CHK
                                                        : lacc_pkg::ST_V_CHK;
            end
            lacc_pkg::ST_W_CHK: begin
                if (pw_reg == pv_reg) begin
                    state_next = lacc_pkg::ST_V_CHK;
                end else if (pw_held) begin
                    state_next = lacc_pkg::ST_W_HOLD;
                end
            end
            lacc_pkg::ST_W_HOLD: state_next = lacc_pkg::ST_W_LD;
            lacc_pkg::ST_W_LD:   state_next = lacc_pkg::ST_Z_CHK;
            lacc_pkg::ST_Z_CHK: begin
                if (z_reg == m_reg) begin
                    state_next = lacc_pkg::ST_W_CHK;
                end else if (w_bit) begin
                    state_next = lacc_pkg::ST_Z_LD;
                end
            end
            lacc_pkg::ST_Z_LD: state_next = lacc_pkg::ST_Z_CHK;
            lacc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lacc_pkg::ST_IDLE;
                end
            end
            default: state_next = lacc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_next     = n_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        z_next     = z_reg;
        pu_next    = pu_reg;
        pv_next    = pv_reg;
        pw_next    = pw_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        row_u_next = row_u_reg;
        row_w_next = row_w_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            lacc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    a_next = item.node_a;
                    b_next = item.node_b;
                    if (item.cmd == lacc_pkg::CMD_COMPUTE) begin
                        n_next   = n_clamp;
                        m_next   = m_clamp;
                        i_next   = '0;
                        u_next   = '0;
                        cnt_next = '0;
                    end
                end
            end
            lacc_pkg::ST_RB_RD: begin
                if (i_reg != n_reg && !i_in_store) begin
                    i_next = i_reg + KW'(1);
                end
            end
            lacc_pkg::ST_RB_WR: i_next = i_reg + KW'(1);
            lacc_pkg::ST_U_LD: begin
                row_u_next = row_q;
                pu_next    = pos_stat.npos_q;
                v_next     = '0;
            end
            lacc_pkg::ST_V_CHK: begin
                if (v_reg == m_reg) begin
                    u_next = u_reg + CW'(1);
                end else if (!u_bit) begin
                    v_next = v_reg + CW'(1);
                end
            end
            lacc_pkg::ST_V_LD: begin
                pv_next = pos_stat.npos_q;
                if (pu_reg < pos_stat.npos_q) begin
                    pw_next = pu_reg + NW'(1);
                end else begin
                    v_next = v_reg + CW'(1);
                end
            end
            lacc_pkg::ST_W_CHK: begin
                if (pw_reg == pv_reg) begin
                    v_next = v_reg + CW'(1);
                end else if (!pw_held) begin
                    pw_next = pw_reg + NW'(1);
                end
            end
            lacc_pkg::ST_W_LD: begin
                row_w_next = row_q;
                z_next     = '0;
            end
            lacc_pkg::ST_Z_CHK: begin
                if (z_reg == m_reg) begin
                    pw_next = pw_reg + NW'(1);
                end else if (!w_bit) begin
                    z_next = z_reg + CW'(1);
                end
            end
            lacc_pkg::ST_Z_LD: begin
                if (pos_stat.npos_q > pv_reg && cnt_reg != lacc_pkg::CROSS_MAX) begin
                    cnt_next = cnt_reg + lacc_pkg::CROSS_W'(1);
                end
                z_next = z_reg + CW'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == lacc_pkg::ST_IDLE);
        res_valid = (state_reg == lacc_pkg::ST_DONE) && out_free;
        res_cross = cnt_reg;
        adj_ctrl  = '0;
        pos_ctrl  = '0;
        pos_ctrl.hold_raddr = pw_reg;
        case (state_reg)
            lacc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    case (item.cmd)
                        lacc_pkg::CMD_CLEAR: adj_ctrl.clr = 1'b1;
                        lacc_pkg::CMD_ADD_EDGE: begin
                            adj_ctrl.we    = edge_ok;
                            adj_ctrl.waddr = item.node_a;
                            adj_ctrl.wbit  = item.node_b;
                        end
                        lacc_pkg::CMD_SET_POS: begin
                            pos_ctrl.npos_we    = int'(item.node_a) < SLOTS;
                            pos_ctrl.npos_waddr = item.node_a;
                            pos_ctrl.npos_wdata = item.position;
                        end
                        lacc_pkg::CMD_COMPUTE: pos_ctrl.held_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            lacc_pkg::ST_EDGE_B: begin
                adj_ctrl.we    = 1'b1;
                adj_ctrl.waddr = b_reg;
                adj_ctrl.wbit  = a_reg;
            end
            lacc_pkg::ST_RB_RD: begin
                if (i_reg != n_reg) begin
                    if (i_in_store) begin
                        pos_ctrl.npos_re    = 1'b1;
                        pos_ctrl.npos_raddr = i_reg[NW-1:0];
                    end else begin
                        // nodes past storage have no edges: they only mask a position
                        pos_ctrl.hold_we     = int'(i_reg[NW-1:0]) < SLOTS;
                        pos_ctrl.hold_waddr  = i_reg[NW-1:0];
                        pos_ctrl.hold_wvalid = 1'b0;
                        pos_ctrl.hold_wnode  = i_reg[NW-1:0];
                    end
                end
            end
            lacc_pkg::ST_RB_WR: begin
                pos_ctrl.hold_we     = int'(pos_stat.npos_q) < SLOTS;
                pos_ctrl.hold_waddr  = pos_stat.npos_q;
                pos_ctrl.hold_wvalid = 1'b1;
                pos_ctrl.hold_wnode  = i_reg[NW-1:0];
            end
            lacc_pkg::ST_U_RD: begin
                adj_ctrl.re         = 1'b1;
                adj_ctrl.raddr      = NW'(u_reg);
                pos_ctrl.npos_re    = 1'b1;
                pos_ctrl.npos_raddr = NW'(u_reg);
            end
            lacc_pkg::ST_V_CHK: begin
                pos_ctrl.npos_re    = 1'b1;
                pos_ctrl.npos_raddr = NW'(v_reg);
            end
            lacc_pkg::ST_W_CHK: pos_ctrl.hold_re = 1'b1;
            lacc_pkg::ST_W_HOLD: begin
                adj_ctrl.re    = 1'b1;
                adj_ctrl.raddr = pos_stat.hold_q;
            end
            lacc_pkg::ST_Z_CHK: begin
                pos_ctrl.npos_re    = 1'b1;
                pos_ctrl.npos_raddr = NW'(z_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lacc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        i_reg     <= i_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        z_reg     <= z_next;
        pu_reg    <= pu_next;
        pv_reg    <= pv_next;
        pw_reg    <= pw_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        row_u_reg <= row_u_next;
        row_w_reg <= row_w_next;
        cnt_reg   <= cnt_next;
    end

endmodule

`default_nettype wire

### rtl/core/linear_arrangement_crossing_counter_unit.sv
// Clear and set position act when accepted in ST_IDLE; add edge writes row node_a,
// then row node_b in ST_EDGE_B, and an ignored edge writes neither. Compute rebuilds
// the holder table, then per node u reads its row and position, per edge (u,v) with
// pu<pv walks the inner positions, and per held inner position reads the holder's row
// and checks each neighbor z; one position read port and one counter set the pace.
// Reset: control state and valid bits clear at once; no clearing pass.
// ============================================================================
// linear_arrangement_crossing_counter_unit
// Edge crossing counter for a linear arrangement of a stored graph.
// ============================================================================
`default_nettype none

module linear_arrangement_crossing_counter_unit #(
    parameter int MAX_NODES = lacc_pkg::MAX_NODES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[1:0], node_a[7:2], node_b[13:8], position[19:14], zero pad
    input  wire logic [lacc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // crossings[19:0], zero pad
    output logic [lacc_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lacc_pkg::APB_AW-1:0]    paddr,
    input  wire logic [lacc_pkg::APB_DW-1:0]    pwdata,
    output logic [lacc_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int SLOTS = (MAX_NODES < (1 << lacc_pkg::NODE_W))
                           ? MAX_NODES : (1 << lacc_pkg::NODE_W);

    lacc_pkg::item_t     item;
    lacc_pkg::adj_ctrl_t adj_ctrl;
    lacc_pkg::pos_ctrl_t pos_ctrl;
    lacc_pkg::pos_stat_t pos_stat;

    logic [SLOTS-1:0]                 row_q;
    logic [lacc_pkg::COUNT_W-1:0]     node_count_reg;
    logic                             m_tvalid_reg;
    logic [lacc_pkg::CROSS_W-1:0]     m_cross_reg;
    logic                             out_free;
    logic                             res_valid;
    logic [lacc_pkg::CROSS_W-1:0]     res_cross;
    logic                             cfg_wr;

    assign item.cmd      = lacc_pkg::cmd_t'(s_tdata[1:0]);
    assign item.node_a   = s_tdata[7:2];
    assign item.node_b   = s_tdata[13:8];
    assign item.position = s_tdata[19:14];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_wr && paddr[2] == lacc_pkg::REG_NODE_COUNT) begin
            node_count_reg <= pwdata[lacc_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lacc_pkg::REG_NODE_COUNT)
                    ? lacc_pkg::APB_DW'(node_count_reg) : '0;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_cross_reg <= res_cross;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lacc_pkg::M_TDATA_W'(m_cross_reg);

    lacc_seq #(
        .MAX_NODES (MAX_NODES),
        .SLOTS     (SLOTS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .item       (item),
        .node_count (node_count_reg),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_cross  (res_cross),
        .adj_ctrl   (adj_ctrl),
        .row_q      (row_q),
        .pos_ctrl   (pos_ctrl),
        .pos_stat   (pos_stat)
    );

    lacc_adj_store #(
        .SLOTS (SLOTS)
    ) u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (adj_ctrl),
        .row_q   (row_q)
    );

    lacc_pos_store #(
        .SLOTS (SLOTS)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (pos_ctrl),
        .stat    (pos_stat)
    );

endmodule

`default_nettype wire

### rtl/core/lacc_checker.sv
// ============================================================================
// lacc_checker
// Port-level checks of the crossing counter, bound to the top level.
// ============================================================================
`default_nettype none

module lacc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [lacc_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lacc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic s_xfer;
    logic s_compute;

    assign s_xfer    = s_tvalid && s_tready;
    assign s_compute = (s_tdata[1:0] == lacc_pkg::CMD_COMPUTE);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && s_compute |=> !s_tready)
        else $error("ready right after compute transfer");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && !s_compute |=> !$rose(m_tvalid))
        else $error("result after a load command");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[lacc_pkg::M_TDATA_W-1:lacc_pkg::CROSS_W] == '0)
        else $error("result pad bits set");

endmodule

bind linear_arrangement_crossing_counter_unit lacc_checker u_lacc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### verif/tb_linear_arrangement_crossing_counter_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_linear_arrangement_crossing_counter_unit
// Streams clear, add-edge, set-position and compute commands into the
// crossing counter and checks every emitted count against a local model of
// the graph and the arrangement, under several idle and stall patterns.
// ============================================================================

module tb_linear_arrangement_crossing_counter_unit;

    import lacc_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 3000;
    localparam int ITEM_W        = $bits(item_t);

    localparam logic [APB_AW-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // cmd[1:0], node_a[7:2], node_b[13:8], position[19:14], zero pad
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // crossings[19:0], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // model of the graph and the arrangement
    logic [MAX_NODES_DEF-1:0] edge_bits [MAX_NODES_DEF];
    logic [NODE_W-1:0]        pos_of [MAX_NODES_DEF];
    logic [COUNT_W-1:0]       cfg_nodes;

    item_t              pending_cmds[$];
    logic [CROSS_W-1:0] expected_crossings[$];

    logic cmd_taken      = 1'b0;
    int   cycle_cnt      = 0;
    int   fail_cnt       = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_start     = -1;
    int   hold_left      = 0;

    linear_arrangement_crossing_counter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic logic [CROSS_W-1:0] tally_crossings();
        int     n, pu, pv, owner;
        int     owner_of [MAX_NODES_DEF];
        bit     owned [MAX_NODES_DEF];
        longint total;
        n = (cfg_nodes > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(cfg_nodes);
        if (n < MIN_NODES) return '0;
        total = 0;
        foreach (owned[i]) owned[i] = 1'b0;
        // last writer in node order owns a shared position
        for (int i = 0; i < n; i++) begin
            owner_of[pos_of[i]] = i;
            owned[pos_of[i]]    = 1'b1;
        end
        for (int u = 0; u < n; u++) begin
            pu = pos_of[u];
            for (int v = 0; v < n; v++) begin
                pv = pos_of[v];
                if (edge_bits[u][v] && pu < pv) begin
                    for (int pw = pu + 1; pw < pv; pw++) begin
                        if (owned[pw]) begin
                            owner = owner_of[pw];
                            for (int z = 0; z < n; z++)
                                if (edge_bits[owner][z] && pos_of[z] > pv) total++;
                        end
                    end
                end
            end
        end
        if (total > CROSS_MAX) return CROSS_MAX;
        return total[CROSS_W-1:0];
    endfunction

    // input side: model update on each accepted transfer; output side: check
    always @(posedge aclk) begin
        item_t              taken;
        logic [CROSS_W-1:0] want;
        cycle_cnt++;
        if (aresetn && s_tvalid && s_tready) begin
            taken = item_t'(s_tdata[ITEM_W-1:0]);
            cmd_taken = 1'b1;
            case (taken.cmd)
                CMD_CLEAR: begin
                    foreach (edge_bits[i]) edge_bits[i] = '0;
                end
                CMD_ADD_EDGE: begin
                    if (taken.node_a != taken.node_b) begin
                        edge_bits[taken.node_a][taken.node_b] = 1'b1;
                        edge_bits[taken.node_b][taken.node_a] = 1'b1;
                    end
                end
                CMD_SET_POS: begin
                    pos_of[taken.node_a] = taken.position;
                end
                CMD_COMPUTE: begin
                    expected_crossings.push_back(tally_crossings());
                end
                default: ;
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_crossings.size() == 0) begin
                $error("crossings: expected no transfer, got %0d", m_tdata[CROSS_W-1:0]);
                fail_cnt++;
            end else begin
                want = expected_crossings.pop_front();
                if (m_tdata[CROSS_W-1:0] !== want) begin
                    $error("crossings: expected %0d, got %0d", want, m_tdata[CROSS_W-1:0]);
                    fail_cnt++;
                end
            end
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!s_tvalid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (aresetn && pending_cmds.size() != 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                s_tdata  <= {{(S_TDATA_W - ITEM_W){1'b0}}, pending_cmds.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (cycle_cnt == hold_start) hold_left = LONG_HOLD;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    task automatic queue_cmd(cmd_t c, int a = 0, int b = 0, int p = 0);
        item_t it;
        it.cmd      = c;
        it.node_a   = a[NODE_W-1:0];
        it.node_b   = b[NODE_W-1:0];
        it.position = p[NODE_W-1:0];
        pending_cmds.push_back(it);
    endtask

    task automatic queue_noise();
        queue_cmd(cmd_t'($urandom_range(3, 0)), $urandom_range(63, 0),
                  $urandom_range(63, 0), $urandom_range(63, 0));
    endtask

    task automatic queue_graph(int n, int edges);
        int a, b, lim;
        lim = (n < 2) ? 3 : n - 1;
        repeat (edges) begin
            a = $urandom_range(lim, 0);
            b = $urandom_range(lim, 0);
            case ($urandom_range(9, 0))
                0: begin
                    a = $urandom_range(63, 0);
                    b = $urandom_range(63, 0);
                end
                1: b = a;
                default: ;
            endcase
            queue_cmd(CMD_ADD_EDGE, a, b, $urandom_range(63, 0));
        end
    endtask

    // random permutation of 0..n-1 shifted by offset, for nodes 0..n-1
    task automatic queue_arrangement(int n, int offset);
        int order [MAX_NODES_DEF];
        int j, t;
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < n; i++)
            queue_cmd(CMD_SET_POS, i, $urandom_range(63, 0), order[i] + offset);
    endtask

    // sampled at the rising edge, where driver and monitor state is settled
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_crossings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_node_count(int value);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NODE_COUNT_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        cfg_nodes = value[COUNT_W-1:0];
        @(negedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        if (got !== APB_DW'(cfg_nodes)) begin
            $error("node_count: expected %0d, got %0d", cfg_nodes, got);
            fail_cnt++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_small_segment();
        int n;
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 0) : $urandom_range(12, 4);
        set_node_count(n);
        if ($urandom_range(4, 0) != 0)
            queue_cmd(CMD_CLEAR, $urandom_range(63, 0), $urandom_range(63, 0),
                      $urandom_range(63, 0));
        queue_graph(n, $urandom_range(2 * n + 2, n));
        repeat ($urandom_range(4, 2)) begin
            queue_arrangement(n, ($urandom_range(3, 0) == 0) ? $urandom_range(64 - n, 0) : 0);
            if ($urandom_range(3, 0) == 0) queue_noise();
            queue_cmd(CMD_COMPUTE, $urandom_range(63, 0), $urandom_range(63, 0),
                      $urandom_range(63, 0));
        end
        repeat ($urandom_range(10, 4)) queue_noise();
    endtask

    // full storage: sparse graph only, the compute walk grows fast with edges
    task automatic run_full_segment(int count_value);
        set_node_count(count_value);
        queue_cmd(CMD_CLEAR);
        queue_graph(MAX_NODES_DEF, 5);
        repeat (2) begin
            queue_arrangement(MAX_NODES_DEF, 0);
            queue_cmd(CMD_COMPUTE);
        end
    endtask

    initial begin
        foreach (pos_of[i]) pos_of[i] = NODE_W'(i);
        foreach (edge_bits[i]) edge_bits[i] = '0;
        cfg_nodes = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        set_node_count(0);
        queue_cmd(CMD_COMPUTE);
        wait_idle();
        set_node_count(3);
        queue_cmd(CMD_ADD_EDGE, 0, 2);
        queue_cmd(CMD_ADD_EDGE, 1, 3);
        queue_cmd(CMD_COMPUTE);
        wait_idle();
        set_node_count(4);
        queue_cmd(CMD_COMPUTE);
        queue_cmd(CMD_ADD_EDGE, 2, 2, 63);
        queue_cmd(CMD_ADD_EDGE, 63, 0);
        queue_cmd(CMD_SET_POS, 63, 0, 63);
        queue_cmd(CMD_SET_POS, 1, 0, 2);
        queue_cmd(CMD_SET_POS, 2, 0, 1);
        queue_cmd(CMD_COMPUTE);
        queue_cmd(CMD_SET_POS, 0, 63, 63);
        queue_cmd(CMD_COMPUTE);
        queue_cmd(CMD_SET_POS, 3, 0, 2);
        queue_cmd(CMD_COMPUTE);
        queue_cmd(CMD_SET_POS, 0, 0, 0);
        queue_cmd(CMD_CLEAR, 63, 63, 63);
        queue_cmd(CMD_COMPUTE, 63, 63, 63);
        wait_idle();
        set_node_count(127);
        queue_cmd(CMD_ADD_EDGE, 0, 63);
        queue_cmd(CMD_ADD_EDGE, 62, 1);
        queue_cmd(CMD_ADD_EDGE, 5, 40);
        queue_cmd(CMD_ADD_EDGE, 30, 60);
        queue_cmd(CMD_COMPUTE);
        wait_idle();
        set_node_count(64);
        queue_cmd(CMD_COMPUTE);
        wait_idle();

        // random
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            for (int seg = 0; seg < 6; seg++) begin
                if (mode == 0 && seg == 2) begin
                    // output held off while computes keep coming
                    set_node_count(4);
                    queue_cmd(CMD_CLEAR);
                    queue_cmd(CMD_ADD_EDGE, 0, 2);
                    queue_cmd(CMD_ADD_EDGE, 1, 3);
                    hold_start = cycle_cnt + 2;
                    repeat (12) begin
                        queue_arrangement(4, $urandom_range(60, 0));
                        queue_cmd(CMD_COMPUTE);
                    end
                end else if (seg == 5 && (mode == 1 || mode == 3)) begin
                    run_full_segment(mode == 1 ? 64 : 127);
                end else begin
                    run_small_segment();
                end
                wait_idle();
            end
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/lacc_pkg.sv
rtl/core/lacc_adj_store.sv
rtl/core/lacc_pos_store.sv
rtl/core/lacc_seq.sv
rtl/core/linear_arrangement_crossing_counter_unit.sv
rtl/core/lacc_checker.sv
verif/tb_linear_arrangement_crossing_counter_unit.sv
